>>> rtl/core/stb_pkg.sv
package stb_pkg;

  localparam int NUM_SLOTS   = 8;
  localparam int COUNT_W     = 16;
  localparam int SLOT_ID_W   = 6;
  localparam int PERIOD_W    = 16;
  localparam int REPEAT_W    = 4;
  localparam int MASK_W      = 8;

  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_CREATE = 2'd1;
  localparam logic [1:0] OP_CANCEL = 2'd2;
  localparam logic [1:0] OP_CHECK  = 2'd3;

  localparam logic [REPEAT_W-1:0] REPEAT_ENDLESS = 4'hF;

  // decoded command broadcast to every cell
  typedef struct packed {
    logic                tick;
    logic                create;
    logic                cancel;
    logic                check;
    logic [COUNT_W-1:0]  period;
    logic [REPEAT_W-1:0] repeat_total;
  } cmd_t;

  // per-cell status back to the top level
  typedef struct packed {
    logic claim;
    logic fired;
    logic hit;
  } cell_stat_t;

endpackage

>>> rtl/core/stb_cell.sv
module stb_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  stb_pkg::cmd_t     cmd,
  input  logic              sel,
  input  logic              free_in,
  output logic              free_out,
  output stb_pkg::cell_stat_t stat
);
  import stb_pkg::*;

  logic                active_r, active_nxt;
  logic                pend_r, pend_nxt;
  logic [COUNT_W-1:0]  elapsed_r, elapsed_nxt;
  logic [COUNT_W-1:0]  period_r, period_nxt;
  logic [REPEAT_W-1:0] limit_r, limit_nxt;
  logic [REPEAT_W-1:0] fcnt_r, fcnt_nxt;

  logic                claim;
  logic                expire;
  logic [REPEAT_W-1:0] fcnt_inc;
  logic                fire;

  // lowest free slot takes the claim token, busy slots pass it up
  assign claim    = cmd.create & free_in & ~active_r;
  assign free_out = free_in & active_r;

  assign expire   = cmd.tick & active_r & (elapsed_r == period_r);
  assign fcnt_inc = fcnt_r + REPEAT_W'(1);
  assign fire     = expire & ((limit_r == REPEAT_ENDLESS) | (fcnt_inc <= limit_r));

  always_comb begin
    active_nxt  = active_r;
    pend_nxt    = pend_r;
    elapsed_nxt = elapsed_r;
    period_nxt  = period_r;
    limit_nxt   = limit_r;
    fcnt_nxt    = fcnt_r;
    if (cmd.tick && active_r) begin
      if (!expire) begin
        elapsed_nxt = elapsed_r + COUNT_W'(1);
      end else begin
        elapsed_nxt = '0;
        if (limit_r != REPEAT_ENDLESS) begin
          fcnt_nxt = fcnt_inc;
        end
        if (fire) begin
          pend_nxt = 1'b1;
        end else begin
          // repeat count used up: auto-cancel
          active_nxt = 1'b0;
          pend_nxt   = 1'b0;
          period_nxt = '0;
          limit_nxt  = '0;
          fcnt_nxt   = '0;
        end
      end
    end
    if (claim) begin
      active_nxt  = 1'b1;
      pend_nxt    = 1'b0;
      elapsed_nxt = '0;
      period_nxt  = cmd.period;
      limit_nxt   = cmd.repeat_total;
      fcnt_nxt    = '0;
    end
    if (cmd.cancel && sel) begin
      active_nxt  = 1'b0;
      pend_nxt    = 1'b0;
      elapsed_nxt = '0;
      period_nxt  = '0;
      limit_nxt   = '0;
      fcnt_nxt    = '0;
    end
    if (cmd.check && sel) begin
      pend_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= 1'b0;
      pend_r    <= 1'b0;
      elapsed_r <= '0;
      period_r  <= '0;
      limit_r   <= '0;
      fcnt_r    <= '0;
    end else begin
      active_r  <= active_nxt;
      pend_r    <= pend_nxt;
      elapsed_r <= elapsed_nxt;
      period_r  <= period_nxt;
      limit_r   <= limit_nxt;
      fcnt_r    <= fcnt_nxt;
    end
  end

  assign stat.claim = claim;
  assign stat.fired = fire;
  assign stat.hit   = cmd.check & sel & pend_r;

endmodule

>>> rtl/core/software_timer_bank.sv
// Bank of independent timer slots driven by one request per clock. A request
// (tick, create, cancel, check) is taken on any edge with start high; busy
// never rises, so a new request may follow every cycle. The answer appears
// in the next cycle on the out_ ports for exactly one cycle, flagged by
// out_valid, and the receiver cannot stall it. All the work is done in the row
// of slot cells: each cell updates its own slot in the accept cycle
// and the claim token for create ripples through the row in that same cycle.
// Slot ids at or above the slot count fail cancel and check; only the first
// eight slots have a bit in out_fired_mask.
module software_timer_bank (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_op,
  input  logic [stb_pkg::SLOT_ID_W-1:0] in_slot_id,
  input  logic [stb_pkg::PERIOD_W-1:0]  in_period,
  input  logic [stb_pkg::REPEAT_W-1:0]  in_repeat_total,
  output logic                          out_valid,
  output logic                          out_success,
  output logic [stb_pkg::SLOT_ID_W-1:0] out_assigned_id,
  output logic [stb_pkg::MASK_W-1:0]    out_fired_mask
);
  import stb_pkg::*;

  cmd_t                 cmd;
  logic [NUM_SLOTS:0]   free_chain;   // claim token between neighbor cells
  cell_stat_t           stat [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] claim_vec;
  logic [NUM_SLOTS-1:0] fired_vec;
  logic [NUM_SLOTS-1:0] hit_vec;
  logic [MASK_W-1:0]    mask;
  logic [SLOT_ID_W-1:0] claim_id;
  logic                 id_ok;
  logic                 success;

  logic                 valid_r;
  logic                 success_r;
  logic [SLOT_ID_W-1:0] assigned_r;
  logic [MASK_W-1:0]    mask_r;

  // one request per cycle, nothing to hold off
  assign busy = 1'b0;

  // decode the request once, broadcast it to all cells
  assign cmd.tick         = start & (in_op == OP_TICK);
  assign cmd.create       = start & (in_op == OP_CREATE);
  assign cmd.cancel       = start & (in_op == OP_CANCEL);
  assign cmd.check        = start & (in_op == OP_CHECK);
  assign cmd.period       = COUNT_W'(in_period);
  assign cmd.repeat_total = in_repeat_total;

  assign free_chain[0] = 1'b1;

  genvar g;
  generate
    for (g = 0; g < NUM_SLOTS; g++) begin : g_cell
      stb_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sel      (in_slot_id == SLOT_ID_W'(g)),
        .free_in  (free_chain[g]),
        .free_out (free_chain[g+1]),
        .stat     (stat[g])
      );
      assign claim_vec[g] = stat[g].claim;
      assign fired_vec[g] = stat[g].fired;
      assign hit_vec[g]   = stat[g].hit;
    end
    // slots below MASK_W show up in the fired mask, spare mask bits stay zero
    for (g = 0; g < MASK_W; g++) begin : g_mask
      if (g < NUM_SLOTS) begin : g_on
        assign mask[g] = fired_vec[g];
      end else begin : g_off
        assign mask[g] = 1'b0;
      end
    end
  endgenerate

  // at most one cell claims, so an or of indexes encodes it
  always_comb begin
    claim_id = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (claim_vec[i]) begin
        claim_id = claim_id | SLOT_ID_W'(i);
      end
    end
  end

  assign id_ok = ({1'b0, in_slot_id} < (SLOT_ID_W + 1)'(NUM_SLOTS));

  // token still free past the last cell: every slot is busy
  always_comb begin
    unique case (in_op)
      OP_TICK:   success = 1'b0;
      OP_CREATE: success = ~free_chain[NUM_SLOTS];
      OP_CANCEL: success = id_ok;
      OP_CHECK:  success = |hit_vec;
      default:   success = 1'b0;
    endcase
  end

  // result register, cleared when no request was taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= 1'b0;
      success_r  <= 1'b0;
      assigned_r <= '0;
      mask_r     <= '0;
    end else begin
      valid_r    <= start;
      success_r  <= start & success;
      assigned_r <= cmd.create ? claim_id : '0;
      mask_r     <= cmd.tick ? mask : '0;
    end
  end

  assign out_valid       = valid_r;
  assign out_success     = success_r;
  assign out_assigned_id = assigned_r;
  assign out_fired_mask  = mask_r;

  // every accepted request yields exactly one result in the next cycle
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start |=> out_valid) and (!start |=> !out_valid))
    else $error("result strobe does not follow request");

  // the claim token lands in at most one cell
  a_single_claim: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(claim_vec))
    else $error("more than one slot claimed");

  // fired bits only come back for a tick
  a_mask_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fired_mask != '0) |-> (out_valid && $past(in_op) == OP_TICK))
    else $error("fired mask outside tick result");

  // a nonzero slot index is only reported with a successful create
  a_id_success: assert property (@(posedge clk) disable iff (!rst_n)
    (out_assigned_id != '0) |-> (out_success && $past(in_op) == OP_CREATE))
    else $error("assigned id without successful create");

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import stb_pkg::*;

  // one answer as it leaves the out_ ports
  typedef struct packed {
    logic                 success;
    logic [SLOT_ID_W-1:0] assigned_id;
    logic [MASK_W-1:0]    fired_mask;
  } answer_t;

  // shadow copy of the timer bank plus the answers it still owes
  class timer_bank_scoreboard;
    bit                slot_on      [NUM_SLOTS];
    bit                timeout_flag [NUM_SLOTS];
    bit [COUNT_W-1:0]  elapsed      [NUM_SLOTS];
    bit [COUNT_W-1:0]  period_val   [NUM_SLOTS];
    bit [REPEAT_W-1:0] repeat_lim   [NUM_SLOTS];
    bit [REPEAT_W-1:0] fire_cnt     [NUM_SLOTS];
    answer_t           answers_due[$];
    int unsigned       mismatches;

    function new();
      int s;
      for (s = 0; s < NUM_SLOTS; s++) clear_slot(s);
      mismatches = 0;
    endfunction

    function void clear_slot(int s);
      slot_on[s]      = 1'b0;
      timeout_flag[s] = 1'b0;
      elapsed[s]      = '0;
      period_val[s]   = '0;
      repeat_lim[s]   = '0;
      fire_cnt[s]     = '0;
    endfunction

    // advance the shadow bank by one request and queue the answer it owes
    function void note_request(logic [1:0] op, logic [SLOT_ID_W-1:0] id,
                               logic [PERIOD_W-1:0] per, logic [REPEAT_W-1:0] rep);
      answer_t ans;
      bit      fire;
      int      s;
      ans = '0;
      case (op)
        OP_TICK: begin
          for (s = 0; s < NUM_SLOTS; s++) begin
            if (!slot_on[s]) continue;
            if (elapsed[s] != period_val[s]) begin
              elapsed[s] = elapsed[s] + 1'b1;
              continue;
            end
            elapsed[s] = '0;
            fire = 1'b0;
            if (repeat_lim[s] == REPEAT_ENDLESS) begin
              fire = 1'b1;
            end else begin
              fire_cnt[s] = fire_cnt[s] + 1'b1;
              if (fire_cnt[s] <= repeat_lim[s]) fire = 1'b1;
              else clear_slot(s);
            end
            if (fire) begin
              timeout_flag[s] = 1'b1;
              if (s < MASK_W) ans.fired_mask[s] = 1'b1;
            end
          end
        end
        OP_CREATE: begin
          for (s = 0; s < NUM_SLOTS; s++) begin
            if (!slot_on[s]) begin
              clear_slot(s);
              slot_on[s]    = 1'b1;
              period_val[s] = per[COUNT_W-1:0];
              repeat_lim[s] = rep;
              ans.success     = 1'b1;
              ans.assigned_id = SLOT_ID_W'(s);
              break;
            end
          end
        end
        OP_CANCEL: begin
          if (int'(id) < NUM_SLOTS) begin
            clear_slot(int'(id));
            ans.success = 1'b1;
          end
        end
        default: begin
          if (int'(id) < NUM_SLOTS && timeout_flag[id]) begin
            timeout_flag[id] = 1'b0;
            ans.success      = 1'b1;
          end
        end
      endcase
      answers_due.push_back(ans);
    endfunction

    function void check_answer(answer_t got);
      answer_t want;
      if (answers_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected answer success=%0b id=%0d mask=%02h",
                   $realtime, got.success, got.assigned_id, got.fired_mask);
        return;
      end
      want = answers_due.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: answer mismatch: expected success=%0b id=%0d mask=%02h, got success=%0b id=%0d mask=%02h",
                   $realtime, want.success, want.assigned_id, want.fired_mask,
                   got.success, got.assigned_id, got.fired_mask);
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [1:0]           in_op;
  logic [SLOT_ID_W-1:0] in_slot_id;
  logic [PERIOD_W-1:0]  in_period;
  logic [REPEAT_W-1:0]  in_repeat_total;
  logic                 out_valid;
  logic                 out_success;
  logic [SLOT_ID_W-1:0] out_assigned_id;
  logic [MASK_W-1:0]    out_fired_mask;

  timer_bank_scoreboard bank_shadow;
  bit                   burst_mode;

  software_timer_bank u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_op           (in_op),
    .in_slot_id      (in_slot_id),
    .in_period       (in_period),
    .in_repeat_total (in_repeat_total),
    .out_valid       (out_valid),
    .out_success     (out_success),
    .out_assigned_id (out_assigned_id),
    .out_fired_mask  (out_fired_mask)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // hard stop in case the bank hangs or stops answering
  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  // one process sees both sides of each edge, so an answer can never be
  // checked ahead of the request that caused it
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy)
        bank_shadow.note_request(in_op, in_slot_id, in_period, in_repeat_total);
      if (out_valid)
        bank_shadow.check_answer({out_success, out_assigned_id, out_fired_mask});
    end
  end

  // present one request after a random pause (none in burst mode) and hold it until taken;
  // start is touched at most once per falling edge
  task automatic send_request(input logic [1:0] op, input logic [SLOT_ID_W-1:0] id,
                              input logic [PERIOD_W-1:0] per,
                              input logic [REPEAT_W-1:0] rep);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 13);
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start           <= 1'b1;
    in_op           <= op;
    in_slot_id      <= id;
    in_period       <= per;
    in_repeat_total <= rep;
    do @(posedge clk); while (busy);
  endtask

  // mostly short periods so slots expire often, now and then a wide one
  function automatic logic [PERIOD_W-1:0] pick_period();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return PERIOD_W'($urandom_range(0, 3));
    if (r < 95) return PERIOD_W'($urandom_range(0, 20));
    return PERIOD_W'($urandom);
  endfunction

  // ids mostly inside the bank, sometimes anywhere in the 6-bit range
  function automatic logic [SLOT_ID_W-1:0] pick_slot();
    if ($urandom_range(0, 99) < 85) return SLOT_ID_W'($urandom_range(0, NUM_SLOTS - 1));
    return SLOT_ID_W'($urandom_range(0, 63));
  endfunction

  initial begin
    int         n;
    int         r;
    logic [1:0] op;

    bank_shadow     = new();
    burst_mode      = 1'b0;
    rst_n           = 1'b0;
    start           = 1'b0;
    in_op           = OP_TICK;
    in_slot_id      = '0;
    in_period       = '0;
    in_repeat_total = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part
    send_request(OP_CHECK,  0,  0, 0);          // check with nothing pending
    send_request(OP_CANCEL, 63, 0, 0);          // id far out of range
    send_request(OP_CANCEL, SLOT_ID_W'(NUM_SLOTS), 0, 0);   // first id past the bank
    send_request(OP_CANCEL, 5,  0, 0);          // cancel of an idle slot
    send_request(OP_CREATE, 0,  0, 1);          // one-shot, expires every tick
    send_request(OP_CREATE, 0,  1, 0);          // repeat zero never fires
    send_request(OP_CREATE, 0,  0, REPEAT_ENDLESS);
    send_request(OP_CREATE, 0,  16'hFFFF, REPEAT_ENDLESS);
    send_request(OP_CREATE, 0,  2, 2);
    send_request(OP_CREATE, 63, 0, 14);
    send_request(OP_CREATE, 0,  3, 7);
    send_request(OP_CREATE, 0,  1, 1);
    send_request(OP_CREATE, 0,  5, 5);          // bank full, must fail
    send_request(OP_TICK,   0,  0, 0);
    send_request(OP_TICK,   63, 16'hFFFF, 4'hF); // auto-cancel drops a pending flag
    send_request(OP_CHECK,  0,  0, 0);
    send_request(OP_CHECK,  2,  0, 0);
    send_request(OP_CHECK,  2,  0, 0);          // flag already cleared
    send_request(OP_CHECK,  63, 0, 0);
    send_request(OP_CREATE, 0,  0, 3);          // reuses the freed lowest slot
    send_request(OP_CANCEL, 3,  0, 0);
    send_request(OP_TICK,   0,  0, 0);
    send_request(OP_TICK,   0,  0, 0);
    send_request(OP_TICK,   0,  0, 0);

    // random part: tick heavy so timers actually run out, with bursts of
    // back-to-back requests mixed with randomly spaced ones
    for (n = 0; n < 1450; n++) begin
      if (n % 150 == 0) burst_mode = ($urandom_range(0, 2) == 0);
      r = $urandom_range(0, 99);
      if (r < 45)      op = OP_TICK;
      else if (r < 65) op = OP_CREATE;
      else if (r < 80) op = OP_CANCEL;
      else             op = OP_CHECK;
      send_request(op, pick_slot(), pick_period(), REPEAT_W'($urandom_range(0, 15)));
    end

    @(negedge clk);
    start <= 1'b0;

    // drain, then give a late or extra answer a chance to show up
    while (bank_shadow.answers_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    if (bank_shadow.mismatches == 0 && bank_shadow.answers_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> software_timer_bank.f
rtl/core/stb_pkg.sv
rtl/core/stb_cell.sv
rtl/core/software_timer_bank.sv
tb/tb.sv
